### src/tpu_pkg.sv
package tpu_pkg;

  // Field widths
  localparam int POS_W   = 32;
  localparam int VEL_W   = 48;
  localparam int SUM_W   = VEL_W + 1;
  localparam int MAG_W   = SUM_W;
  localparam int DT_W    = 32;
  localparam int LIM_W   = 47;
  localparam int PER_W   = 31;

  // Internal widths
  localparam int SQ_W    = 98;            // sum of three squared magnitudes
  localparam int NUM_W   = 97;            // magnitude times twice the limit
  localparam int ROOT_W  = SQ_W / 2;
  localparam int DM_W    = 36;            // rounded displacement magnitude
  localparam int X_W     = 40;            // position before folding
  localparam int FQ_W    = X_W - 1;       // magnitude of offset from center

  // Stream widths
  localparam int IN_W    = 3 * POS_W + 6 * VEL_W;
  localparam int OUT_DW  = 3 * POS_W + 3 * VEL_W + 1;
  localparam int OUT_W   = ((OUT_DW + 7) / 8) * 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = LIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP   = 3'd0,
    REG_CENTER_X    = 3'd1,
    REG_CENTER_Y    = 3'd2,
    REG_CENTER_Z    = 3'd3,
    REG_PERIOD_X    = 3'd4,
    REG_PERIOD_Y    = 3'd5,
    REG_PERIOD_Z    = 3'd6,
    REG_SPEED_LIMIT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][VEL_W-1:0] up;
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } node_t;

  typedef struct packed {
    node_t                 nd;
    logic                  clip;
    logic [2:0][NUM_W-1:0] num;
  } sq_sb_t;

  typedef struct packed {
    node_t nd;
    logic  clip;
  } cd_sb_t;

  typedef struct packed {
    logic [2:0][X_W-1:0]   x;
    logic [2:0]            tneg;
    logic [2:0][VEL_W-1:0] up;
    logic                  clip;
  } fd_sb_t;

endpackage

### src/trapezoid_position_update_pbc_unit.sv
// Trapezoidal position update with periodic folding, one node per item.
// in_* carries a node (old position, current and previous velocity); out_*
// returns the folded position, the previous velocity actually used and a
// flag set when the average velocity was scaled to the speed limit.
// cfg_* writes the time step, box center, box periods and speed limit;
// cfg_ready is always high; registers are to change only while no item is
// in flight, which the user must ensure: the block does not enforce it.
// Throughput is one item per cycle unless the output stalls. The pipeline has
// 149 register stages. Most of that depth is the bit-per-stage square root
// (49), the clip divider (49) and the folding divider (39), plus twelve
// stages of multiply, add and rounding logic.
// The pipeline moves as a whole: when out_tvalid is high and out_tready is
// low every stage holds and in_tready drops; empty stages do not collapse.
// A synchronous reset (rst_n low) empties the pipeline and clears all
// configuration registers to zero (no limit, no folding, zero time step).
module trapezoid_position_update_pbc_unit
  import tpu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // old_pos_x/y/z (3x32), cur_vel_x/y/z (3x48), prev_vel_x/y/z (3x48)
  input  logic [IN_W-1:0]      in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // new_pos_x/y/z (3x32), used_prev_vel_x/y/z (3x48), speed_clipped, zero pad
  output logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AL_W = 25;
  localparam int AH_W = MAG_W - AL_W;
  localparam int TW_W = LIM_W + 1;
  localparam int TL_W = TW_W / 2;
  localparam int TH_W = TW_W - TL_W;
  localparam int DP_W = MAG_W + DT_W;
  localparam int DSH  = 45;
  localparam int R_W  = PER_W + 2;
  localparam int F_W  = X_W + 1;

  // Configuration
  logic [DT_W-1:0]         time_step_r;
  logic [2:0][POS_W-1:0]   center_r;
  logic [2:0][PER_W-1:0]   period_r;
  logic [LIM_W-1:0]        speed_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r   <= '0;
      center_r      <= '0;
      period_r      <= '0;
      speed_limit_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIME_STEP:   time_step_r   <= cfg_data[DT_W-1:0];
        REG_CENTER_X:    center_r[0]   <= cfg_data[POS_W-1:0];
        REG_CENTER_Y:    center_r[1]   <= cfg_data[POS_W-1:0];
        REG_CENTER_Z:    center_r[2]   <= cfg_data[POS_W-1:0];
        REG_PERIOD_X:    period_r[0]   <= cfg_data[PER_W-1:0];
        REG_PERIOD_Y:    period_r[1]   <= cfg_data[PER_W-1:0];
        REG_PERIOD_Z:    period_r[2]   <= cfg_data[PER_W-1:0];
        REG_SPEED_LIMIT: speed_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves unless the output is stalled
  logic adv;
  assign adv       = out_tready | ~out_tvalid;
  assign in_tready = adv;

  // Stage 0 logic: unpack, substitute previous velocity, sum and magnitude
  logic [2:0][VEL_W-1:0]   cur_in;
  logic [2:0][VEL_W-1:0]   prv_in;
  logic [SUM_W-1:0]        s_in [3];
  logic                    prv_zero;
  node_t                   nd_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nd_nxt.pos[i] = in_tdata[i*POS_W +: POS_W];
      cur_in[i]     = in_tdata[3*POS_W + i*VEL_W +: VEL_W];
      prv_in[i]     = in_tdata[3*POS_W + 3*VEL_W + i*VEL_W +: VEL_W];
    end
    prv_zero  = (prv_in == '0);
    nd_nxt.up = prv_zero ? cur_in : prv_in;
    for (int i = 0; i < 3; i++) begin
      s_in[i] = SUM_W'($signed(cur_in[i])) + SUM_W'($signed(nd_nxt.up[i]));
      nd_nxt.neg[i] = s_in[i][SUM_W-1];
      nd_nxt.mag[i] = nd_nxt.neg[i] ? MAG_W'(-s_in[i]) : MAG_W'(s_in[i]);
    end
  end

  // Stage registers
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  logic v10_r, v11_r, v12_r;

  node_t nd1_r, nd2_r, nd3_r, nd4_r, nd5_r;

  logic [2*AH_W-1:0]        sqhh2_r [3];
  logic [AH_W+AL_W-1:0]     sqhl2_r [3];
  logic [2*AL_W-1:0]        sqll2_r [3];
  logic [AH_W+TH_W-1:0]     nhh2_r  [3];
  logic [AH_W+TL_W-1:0]     nhl2_r  [3];
  logic [AL_W+TH_W-1:0]     nlh2_r  [3];
  logic [AL_W+TL_W-1:0]     nll2_r  [3];
  logic [2*TH_W-1:0]        lhh2_r;
  logic [TH_W+TL_W-1:0]     lhl2_r;
  logic [2*TL_W-1:0]        lll2_r;

  logic [SQ_W-1:0]          sq3_r [3];
  logic [2:0][NUM_W-1:0]    num3_r, num4_r, num5_r;
  logic [SQ_W-1:0]          lim3_r, lim4_r;
  logic [SQ_W-1:0]          m2_4_r, m2_5_r;
  logic                     clip5_r;

  logic [TW_W-1:0]          twol;
  logic [TH_W-1:0]          th;
  logic [TL_W-1:0]          tl;

  assign twol = {speed_limit_r, 1'b0};
  assign th   = twol[TW_W-1:TL_W];
  assign tl   = twol[TL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: capture the node
      nd1_r <= nd_nxt;

      // Stage 2: partial products of squares, of magnitude times 2L and of 4L^2
      nd2_r <= nd1_r;
      for (int i = 0; i < 3; i++) begin
        sqhh2_r[i] <= (2*AH_W)'(nd1_r.mag[i][MAG_W-1:AL_W])
                    * (2*AH_W)'(nd1_r.mag[i][MAG_W-1:AL_W]);
        sqhl2_r[i] <= (AH_W+AL_W)'(nd1_r.mag[i][MAG_W-1:AL_W])
                    * (AH_W+AL_W)'(nd1_r.mag[i][AL_W-1:0]);
        sqll2_r[i] <= (2*AL_W)'(nd1_r.mag[i][AL_W-1:0])
                    * (2*AL_W)'(nd1_r.mag[i][AL_W-1:0]);
        nhh2_r[i]  <= (AH_W+TH_W)'(nd1_r.mag[i][MAG_W-1:AL_W]) * (AH_W+TH_W)'(th);
        nhl2_r[i]  <= (AH_W+TL_W)'(nd1_r.mag[i][MAG_W-1:AL_W]) * (AH_W+TL_W)'(tl);
        nlh2_r[i]  <= (AL_W+TH_W)'(nd1_r.mag[i][AL_W-1:0]) * (AL_W+TH_W)'(th);
        nll2_r[i]  <= (AL_W+TL_W)'(nd1_r.mag[i][AL_W-1:0]) * (AL_W+TL_W)'(tl);
      end
      lhh2_r <= (2*TH_W)'(th) * (2*TH_W)'(th);
      lhl2_r <= (TH_W+TL_W)'(th) * (TH_W+TL_W)'(tl);
      lll2_r <= (2*TL_W)'(tl) * (2*TL_W)'(tl);

      // Stage 3: assemble the wide products
      nd3_r <= nd2_r;
      for (int i = 0; i < 3; i++) begin
        sq3_r[i]  <= (SQ_W'(sqhh2_r[i]) << (2*AL_W)) + (SQ_W'(sqhl2_r[i]) << (AL_W+1))
                   + SQ_W'(sqll2_r[i]);
        num3_r[i] <= (NUM_W'(nhh2_r[i]) << (AL_W+TL_W)) + (NUM_W'(nhl2_r[i]) << AL_W)
                   + (NUM_W'(nlh2_r[i]) << TL_W) + NUM_W'(nll2_r[i]);
      end
      lim3_r <= (SQ_W'(lhh2_r) << (2*TL_W)) + (SQ_W'(lhl2_r) << (TL_W+1)) + SQ_W'(lll2_r);

      // Stage 4: squared length
      nd4_r  <= nd3_r;
      num4_r <= num3_r;
      lim4_r <= lim3_r;
      m2_4_r <= sq3_r[0] + sq3_r[1] + sq3_r[2];

      // Stage 5: clip decision; equal to the limit is not clipped
      nd5_r   <= nd4_r;
      num5_r  <= num4_r;
      m2_5_r  <= m2_4_r;
      clip5_r <= (speed_limit_r != '0) && (m2_4_r > lim4_r);
    end
  end

  // Square root of the squared length
  sq_sb_t               sq_sb_in, sq_sb;
  logic                 sq_v;
  logic [ROOT_W-1:0]    root;

  assign sq_sb_in = '{nd: nd5_r, clip: clip5_r, num: num5_r};

  tpu_isqrt #(
    .NW (SQ_W),
    .SW ($bits(sq_sb_t))
  ) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (v5_r),
    .n_i     (m2_5_r),
    .sb_i    (sq_sb_in),
    .valid_o (sq_v),
    .root_o  (root),
    .sb_o    (sq_sb)
  );

  // Scale: |s| * 2L / floor(sqrt(m2)) per axis
  cd_sb_t                   cd_sb_in, cd_sb;
  logic                     cd_v;
  logic [2:0][ROOT_W-1:0]   cd_den;
  logic [2:0][MAG_W-1:0]    cd_q;

  assign cd_sb_in = '{nd: sq_sb.nd, clip: sq_sb.clip};
  assign cd_den   = {3{root}};

  tpu_div #(
    .LANES (3),
    .NW    (NUM_W),
    .DW    (ROOT_W),
    .QW    (MAG_W),
    .SW    ($bits(cd_sb_t))
  ) u_clip_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (sq_v),
    .n_i     (sq_sb.num),
    .d_i     (cd_den),
    .sb_i    (cd_sb_in),
    .valid_o (cd_v),
    .q_o     (cd_q),
    .r_o     (),
    .sb_o    (cd_sb)
  );

  // Stages 6 to 9: displacement and offset from the box center
  logic [MAG_W-1:0]         mag6_nxt [3];
  logic [2*DT_W-1:0]        pl6_r [3];
  logic [MAG_W-1:0]         ph6_r [3];
  logic [2:0][POS_W-1:0]    pos6_r, pos7_r;
  logic [2:0][VEL_W-1:0]    up6_r, up7_r, up8_r, up9_r;
  logic [2:0]               neg6_r, neg7_r;
  logic                     clip6_r, clip7_r, clip8_r, clip9_r;
  logic [DM_W-1:0]          dm7_r [3];
  logic [DP_W-1:0]          dp7_nxt [3];
  logic [2:0][X_W-1:0]      x8_r, x9_r;
  logic [X_W-1:0]           t9_nxt [3];
  logic [2:0][FQ_W-1:0]     ta9_r;
  logic [2:0]               tneg9_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag6_nxt[i] = cd_sb.clip ? cd_q[i] : cd_sb.nd.mag[i];
      dp7_nxt[i]  = (DP_W'(ph6_r[i]) << DT_W) + DP_W'(pl6_r[i]) + (DP_W'(1) << (DSH-1));
      t9_nxt[i]   = x8_r[i] - X_W'($signed(center_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
    end else if (adv) begin
      v6_r <= cd_v;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 6: magnitude times dt, split low 32 and high bits
      pos6_r  <= cd_sb.nd.pos;
      up6_r   <= cd_sb.nd.up;
      neg6_r  <= cd_sb.nd.neg;
      clip6_r <= cd_sb.clip;
      for (int i = 0; i < 3; i++) begin
        pl6_r[i] <= (2*DT_W)'(mag6_nxt[i][DT_W-1:0]) * (2*DT_W)'(time_step_r);
        ph6_r[i] <= MAG_W'(mag6_nxt[i][MAG_W-1:DT_W]) * MAG_W'(time_step_r);
      end

      // Stage 7: round half away from zero on the magnitude
      pos7_r  <= pos6_r;
      up7_r   <= up6_r;
      neg7_r  <= neg6_r;
      clip7_r <= clip6_r;
      for (int i = 0; i < 3; i++) begin
        dm7_r[i] <= dp7_nxt[i][DSH +: DM_W];
      end

      // Stage 8: advance the position
      up8_r   <= up7_r;
      clip8_r <= clip7_r;
      for (int i = 0; i < 3; i++) begin
        x8_r[i] <= X_W'($signed(pos7_r[i]))
                 + (neg7_r[i] ? -X_W'(dm7_r[i]) : X_W'(dm7_r[i]));
      end

      // Stage 9: offset from center, sign and magnitude
      x9_r    <= x8_r;
      up9_r   <= up8_r;
      clip9_r <= clip8_r;
      for (int i = 0; i < 3; i++) begin
        tneg9_r[i] <= t9_nxt[i][X_W-1];
        ta9_r[i]   <= t9_nxt[i][X_W-1] ? FQ_W'(-t9_nxt[i]) : FQ_W'(t9_nxt[i]);
      end
    end
  end

  // Folding divider: |t| / period
  fd_sb_t                  fd_sb_in, fd_sb;
  logic                    fd_v;
  logic [2:0][FQ_W-1:0]    fd_q;
  logic [2:0][PER_W-1:0]   fd_r;

  assign fd_sb_in = '{x: x9_r, tneg: tneg9_r, up: up9_r, clip: clip9_r};

  tpu_div #(
    .LANES (3),
    .NW    (FQ_W),
    .DW    (PER_W),
    .QW    (FQ_W),
    .SW    ($bits(fd_sb_t))
  ) u_fold_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (v9_r),
    .n_i     (ta9_r),
    .d_i     (period_r),
    .sb_i    (fd_sb_in),
    .valid_o (fd_v),
    .q_o     (fd_q),
    .r_o     (fd_r),
    .sb_o    (fd_sb)
  );

  // Stages 10 to 12: floor remainder, half-even rounding, recenter, saturate
  logic [2:0]               wrap10_nxt;
  logic [2:0][PER_W-1:0]    r10_r;
  logic [2:0]               qodd10_r;
  logic [2:0][X_W-1:0]      x10_r, x11_r;
  logic [2:0][VEL_W-1:0]    up10_r, up11_r, up12_r;
  logic                     clip10_r, clip11_r, clip12_r;
  logic [2:0]               rnd11_nxt;
  logic [R_W-1:0]           r11_r [3];
  logic signed [F_W-1:0]    f12_nxt [3];
  logic [2:0][POS_W-1:0]    pos12_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wrap10_nxt[i] = fd_sb.tneg[i] && (fd_r[i] != '0);
      rnd11_nxt[i]  = ({r10_r[i], 1'b0} > {1'b0, period_r[i]})
                   || (({r10_r[i], 1'b0} == {1'b0, period_r[i]}) && qodd10_r[i]);
      f12_nxt[i]    = (period_r[i] != '0)
                    ? F_W'($signed(center_r[i])) + F_W'($signed(r11_r[i]))
                    : F_W'($signed(x11_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0; v11_r <= 1'b0; v12_r <= 1'b0;
    end else if (adv) begin
      v10_r <= fd_v;
      v11_r <= v10_r;
      v12_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 10: turn the magnitude division into a floor division
      x10_r    <= fd_sb.x;
      up10_r   <= fd_sb.up;
      clip10_r <= fd_sb.clip;
      for (int i = 0; i < 3; i++) begin
        r10_r[i]    <= wrap10_nxt[i] ? period_r[i] - fd_r[i] : fd_r[i];
        qodd10_r[i] <= fd_q[i][0] ^ wrap10_nxt[i];
      end

      // Stage 11: round the quotient half to even by adjusting the remainder
      x11_r    <= x10_r;
      up11_r   <= up10_r;
      clip11_r <= clip10_r;
      for (int i = 0; i < 3; i++) begin
        r11_r[i] <= rnd11_nxt[i] ? R_W'(r10_r[i]) - R_W'(period_r[i]) : R_W'(r10_r[i]);
      end

      // Stage 12: output register
      up12_r   <= up11_r;
      clip12_r <= clip11_r;
      for (int i = 0; i < 3; i++) begin
        if (f12_nxt[i][F_W-1:POS_W-1] == '0 || f12_nxt[i][F_W-1:POS_W-1] == '1) begin
          pos12_r[i] <= f12_nxt[i][POS_W-1:0];
        end else begin
          pos12_r[i] <= f12_nxt[i][F_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                          : {1'b0, {(POS_W-1){1'b1}}};
        end
      end
    end
  end

  assign out_tvalid = v12_r;
  assign out_tdata  = {{(OUT_W-OUT_DW){1'b0}}, clip12_r, up12_r, pos12_r};

  a_clip_needs_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && clip12_r) |-> (speed_limit_r != '0))
    else $error("speed clip flagged with no limit set");

  a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cd_v && cd_sb.clip) |-> ((cd_q[0] <= MAG_W'(twol)) && (cd_q[1] <= MAG_W'(twol))
                              && (cd_q[2] <= MAG_W'(twol))))
    else $error("scaled velocity exceeds the limit");

  a_fold_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v10_r |-> (((period_r[0] == '0) || (r10_r[0] < period_r[0]))
            && ((period_r[1] == '0) || (r10_r[1] < period_r[1]))
            && ((period_r[2] == '0) || (r10_r[2] < period_r[2]))))
    else $error("folding remainder not below the period");

endmodule

### src/tpu_isqrt.sv
module tpu_isqrt
  import tpu_pkg::*;
#(
  parameter int NW = SQ_W,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [NW-1:0]     n_i,
  input  logic [SW-1:0]     sb_i,
  output logic              valid_o,
  output logic [NW/2-1:0]   root_o,
  output logic [SW-1:0]     sb_o
);

  localparam int RW = NW / 2;
  localparam int EW = RW + 2;

  logic          v_r    [RW];
  logic [NW-1:0] n_r    [RW];
  logic [RW-1:0] root_r [RW];
  logic [EW-1:0] rem_r  [RW];
  logic [SW-1:0] sb_r   [RW];

  // One root bit per stage, two radicand bits shifted in each time
  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic          v_in;
    logic [NW-1:0] n_in;
    logic [RW-1:0] root_in;
    logic [EW-1:0] rem_in;
    logic [SW-1:0] sb_in;
    logic [EW-1:0] pre;
    logic [EW-1:0] trial;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign n_in    = n_i;
      assign root_in = '0;
      assign rem_in  = '0;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign v_in    = v_r[j-1];
      assign n_in    = n_r[j-1];
      assign root_in = root_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign sb_in   = sb_r[j-1];
    end

    assign pre   = {rem_in[EW-3:0], n_in[NW-1-2*j -: 2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[j]  <= n_in;
        sb_r[j] <= sb_in;
        if (pre >= trial) begin
          rem_r[j]  <= pre - trial;
          root_r[j] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_r[j]  <= pre;
          root_r[j] <= {root_in[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_r[RW-1];
  assign root_o  = root_r[RW-1];
  assign sb_o    = sb_r[RW-1];

  // A floor square root leaves a remainder of at most twice the root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_o |-> (rem_r[RW-1] <= EW'({root_o, 1'b0})))
    else $error("square root remainder out of range");

endmodule

### src/tpu_div.sv
module tpu_div
  import tpu_pkg::*;
#(
  parameter int LANES = 3,
  parameter int NW    = NUM_W,
  parameter int DW    = ROOT_W,
  parameter int QW    = MAG_W,
  parameter int SW    = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       valid_i,
  input  logic [LANES-1:0][NW-1:0]   n_i,
  input  logic [LANES-1:0][DW-1:0]   d_i,
  input  logic [SW-1:0]              sb_i,
  output logic                       valid_o,
  output logic [LANES-1:0][QW-1:0]   q_o,
  output logic [LANES-1:0][DW-1:0]   r_o,
  output logic [SW-1:0]              sb_o
);

  logic                     v_r   [QW];
  logic [LANES-1:0][NW-1:0] n_r   [QW];
  logic [LANES-1:0][DW-1:0] d_r   [QW];
  logic [LANES-1:0][QW-1:0] q_r   [QW];
  logic [LANES-1:0][DW-1:0] rem_r [QW];
  logic [SW-1:0]            sb_r  [QW];

  // Restoring division, one quotient bit per stage; the bits above the
  // quotient preload the remainder
  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic                     v_in;
    logic [LANES-1:0][NW-1:0] n_in;
    logic [LANES-1:0][DW-1:0] d_in;
    logic [LANES-1:0][QW-1:0] q_in;
    logic [LANES-1:0][DW-1:0] rem_in;
    logic [SW-1:0]            sb_in;

    if (j == 0) begin : g_first
      assign v_in  = valid_i;
      assign n_in  = n_i;
      assign d_in  = d_i;
      assign q_in  = '0;
      assign sb_in = sb_i;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        if (NW > QW) begin : g_pre
          assign rem_in[l] = DW'(n_i[l][NW-1:QW]);
        end else begin : g_zero
          assign rem_in[l] = '0;
        end
      end
    end else begin : g_next
      assign v_in   = v_r[j-1];
      assign n_in   = n_r[j-1];
      assign d_in   = d_r[j-1];
      assign q_in   = q_r[j-1];
      assign rem_in = rem_r[j-1];
      assign sb_in  = sb_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_step
      logic [DW:0] pre;
      logic [DW:0] dx;
      assign pre = {rem_in[l], n_in[l][QW-1-j]};
      assign dx  = {1'b0, d_in[l]};

      always_ff @(posedge clk) begin
        if (en) begin
          if (pre >= dx) begin
            rem_r[j][l] <= DW'(pre - dx);
            q_r[j][l]   <= {q_in[l][QW-2:0], 1'b1};
          end else begin
            rem_r[j][l] <= DW'(pre);
            q_r[j][l]   <= {q_in[l][QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[j]  <= n_in;
        d_r[j]  <= d_in;
        sb_r[j] <= sb_in;
      end
    end
  end

  assign valid_o = v_r[QW-1];
  assign q_o     = q_r[QW-1];
  assign r_o     = rem_r[QW-1];
  assign sb_o    = sb_r[QW-1];

endmodule
